// ===== rtl/core/m3i_pkg.sv =====
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, payload types and saturation limits for the 3x3 inverter.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int EW       = 32;          // entry width
	localparam int FB       = 16;          // fraction bits
	localparam int SH       = 2 * FB;      // scale of a product of two entries
	localparam int TW       = 31;          // threshold width
	localparam int AW       = 2 * EW + 1;  // cofactor width
	localparam int DW       = 3 * EW + 4;  // determinant width
	localparam int QB       = EW + 1;      // quotient bits kept by a lane
	localparam int LANE_LAT = QB + 2;      // registers in one divider lane
	localparam int NV       = 5 + LANE_LAT + 1;

	localparam logic signed [EW-1:0] ENTRY_MAX = {1'b0, {(EW-1){1'b1}}};
	localparam logic signed [EW-1:0] ENTRY_MIN = {1'b1, {(EW-1){1'b0}}};

	typedef logic signed [EW-1:0] entry_t;
	typedef logic signed [AW-1:0] adj_t;
	typedef logic signed [DW-1:0] det_t;

	typedef struct packed {
		entry_t a00;
		entry_t a01;
		entry_t a02;
		entry_t a10;
		entry_t a11;
		entry_t a12;
		entry_t a20;
		entry_t a21;
		entry_t a22;
	} in_t;

	typedef struct packed {
		entry_t b00;
		entry_t b01;
		entry_t b02;
		entry_t b10;
		entry_t b11;
		entry_t b12;
		entry_t b20;
		entry_t b21;
		entry_t b22;
		entry_t det_value;
		logic   singular;
	} out_t;

	typedef struct packed {
		logic   sing;
		entry_t dval;
	} side_t;

endpackage

// ===== rtl/core/m3i_cofactor.sv =====
// ----------------------------------------------------------------------------
// m3i_cofactor
// Two-stage adjugate: nine pairs of 32x32 products, then signed differences.
// ----------------------------------------------------------------------------
module m3i_cofactor (
	input  logic            clk,
	input  logic            en,
	input  m3i_pkg::in_t    a,
	output m3i_pkg::adj_t   adj_s2 [9],
	output m3i_pkg::entry_t row0_s2 [3]
);

	// adj[k] = +/-(e[P]*e[Q] - e[R]*e[S])
	localparam int P [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
	localparam int Q [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
	localparam int R [9] = '{5, 2, 2, 5, 2, 3, 4, 1, 3};
	localparam int S [9] = '{7, 7, 4, 6, 6, 2, 6, 6, 1};
	localparam bit NEG [9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

	m3i_pkg::entry_t e [9];
	logic signed [2*m3i_pkg::EW-1:0] pa_s1 [9];
	logic signed [2*m3i_pkg::EW-1:0] pb_s1 [9];
	m3i_pkg::entry_t row0_s1 [3];

	always_comb begin
		e[0] = a.a00; e[1] = a.a01; e[2] = a.a02;
		e[3] = a.a10; e[4] = a.a11; e[5] = a.a12;
		e[6] = a.a20; e[7] = a.a21; e[8] = a.a22;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				pa_s1[k] <= e[P[k]] * e[Q[k]];
				pb_s1[k] <= e[R[k]] * e[S[k]];
			end
			for (int k = 0; k < 3; k++) begin
				row0_s1[k] <= e[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				if (NEG[k]) begin
					adj_s2[k] <= m3i_pkg::AW'(pb_s1[k]) - m3i_pkg::AW'(pa_s1[k]);
				end else begin
					adj_s2[k] <= m3i_pkg::AW'(pa_s1[k]) - m3i_pkg::AW'(pb_s1[k]);
				end
			end
			row0_s2 <= row0_s1;
		end
	end

endmodule

// ===== rtl/core/m3i_det.sv =====
// ----------------------------------------------------------------------------
// m3i_det
// Determinant by first-row expansion, cofactors split into two halves.
// ----------------------------------------------------------------------------
module m3i_det (
	input  logic            clk,
	input  logic            en,
	input  m3i_pkg::entry_t row0 [3],
	input  m3i_pkg::adj_t   cof [3],
	output m3i_pkg::det_t   det_s4
);

	logic signed [m3i_pkg::AW-1:0] pl_s3 [3];
	logic signed [m3i_pkg::AW-1:0] ph_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pl_s3[k] <= $signed({1'b0, cof[k][m3i_pkg::EW-1:0]}) * row0[k];
				ph_s3[k] <= $signed(cof[k][m3i_pkg::AW-1:m3i_pkg::EW]) * row0[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= (m3i_pkg::DW'(ph_s3[0]) << m3i_pkg::EW) + m3i_pkg::DW'(pl_s3[0])
				+ (m3i_pkg::DW'(ph_s3[1]) << m3i_pkg::EW) + m3i_pkg::DW'(pl_s3[1])
				+ (m3i_pkg::DW'(ph_s3[2]) << m3i_pkg::EW) + m3i_pkg::DW'(pl_s3[2]);
		end
	end

endmodule

// ===== rtl/core/m3i_div_lane.sv =====
// ----------------------------------------------------------------------------
// m3i_div_lane
// Pipelined restoring divider for one inverse entry, one quotient bit a stage.
// ----------------------------------------------------------------------------
module m3i_div_lane (
	input  logic                   clk,
	input  logic                   en,
	input  logic [m3i_pkg::AW-1:0] amag,
	input  logic                   neg,
	input  logic [m3i_pkg::DW-1:0] dmag [m3i_pkg::QB+1],
	output m3i_pkg::entry_t        res_q
);

	localparam int QB = m3i_pkg::QB;
	localparam int DW = m3i_pkg::DW;
	localparam logic [QB-1:0] HALF = QB'(1) << (m3i_pkg::EW - 1);

	logic [DW-1:0] rem_q [QB];
	logic [QB-1:0] quo_q [QB+1];
	logic          ovf_q [QB+1];
	logic          neg_q [QB+1];
	logic          lsb_q;

	// Quotient of amag * 2^SH by dmag overflows QB bits when amag >= 2 * dmag.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= DW'(amag >> 1);
			lsb_q    <= amag[0];
			ovf_q[0] <= DW'(amag) >= (dmag[0] << 1);
			quo_q[0] <= '0;
			neg_q[0] <= neg;
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_stage
		logic [DW-1:0] trial;
		logic          take;

		always_comb begin
			trial = {rem_q[j-1][DW-2:0], (j == 1) ? lsb_q : 1'b0};
			take  = trial >= dmag[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[j] <= {quo_q[j-1][QB-2:0], take};
				ovf_q[j] <= ovf_q[j-1];
				neg_q[j] <= neg_q[j-1];
			end
		end

		if (j < QB) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j] <= take ? trial - dmag[j] : trial;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_q[QB]) begin
				res_q <= (ovf_q[QB] || quo_q[QB] > HALF) ? m3i_pkg::ENTRY_MIN
					: -$signed(quo_q[QB][m3i_pkg::EW-1:0]);
			end else begin
				res_q <= (ovf_q[QB] || quo_q[QB] >= HALF) ? m3i_pkg::ENTRY_MAX
					: $signed(quo_q[QB][m3i_pkg::EW-1:0]);
			end
		end
	end

endmodule

// ===== rtl/core/matrix3_inverse.sv =====
// Throughput: one matrix per cycle unless a finished result waits under out_stall;
// the nine divider lanes retire one bit each per stage.
// The whole pipeline advances together and holds only while a result waits under stall.
// Reset (arst_n low) clears all valid bits and sets the singular threshold to 1.
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 Q16.16 matrix inverse by adjugate over determinant, fully pipelined.
// ----------------------------------------------------------------------------
module matrix3_inverse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  m3i_pkg::in_t           in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output m3i_pkg::out_t          out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [m3i_pkg::TW-1:0] cfg_data
);

	localparam int QB = m3i_pkg::QB;
	localparam int LL = m3i_pkg::LANE_LAT;
	localparam int NV = m3i_pkg::NV;

	logic                   en;
	logic [NV-1:0]          vld_q;
	logic [m3i_pkg::TW-1:0] thr_q;

	m3i_pkg::adj_t   adj_s2 [9];
	m3i_pkg::adj_t   adj_s3 [9];
	m3i_pkg::adj_t   adj_s4 [9];
	m3i_pkg::entry_t row0_s2 [3];
	m3i_pkg::adj_t   cof [3];
	m3i_pkg::det_t   det_s4;

	logic [m3i_pkg::AW-1:0] amag_s5 [9];
	logic                   neg_s5 [9];
	logic [m3i_pkg::DW-1:0] dmag_dl [QB+1];
	m3i_pkg::side_t         side_q [LL+1];
	m3i_pkg::entry_t        res [9];
	m3i_pkg::out_t          out_q;

	logic [m3i_pkg::DW-1:0] dmag_c;
	logic [m3i_pkg::DW-1:0] dint_c;
	logic                   dneg_c;

	// Advance everything unless a finished result is held at the output.
	assign en        = !(vld_q[NV-1] && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_q[NV-1];
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= m3i_pkg::TW'(1);
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NV-2:0], in_valid};
		end
	end

	// Stages 1-2: adjugate.
	m3i_cofactor u_cof (
		.clk     (clk),
		.en      (en),
		.a       (in_data),
		.adj_s2  (adj_s2),
		.row0_s2 (row0_s2)
	);

	// Stages 3-4: merge the first-row cofactors into the determinant.
	assign cof[0] = adj_s2[0];
	assign cof[1] = adj_s2[3];
	assign cof[2] = adj_s2[6];

	m3i_det u_det (
		.clk    (clk),
		.en     (en),
		.row0   (row0_s2),
		.cof    (cof),
		.det_s4 (det_s4)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			adj_s3 <= adj_s2;
			adj_s4 <= adj_s3;
		end
	end

	// Stage 5: magnitudes and signs, singular test, determinant output.
	always_comb begin
		dneg_c = det_s4[m3i_pkg::DW-1];
		dmag_c = dneg_c ? m3i_pkg::DW'(-det_s4) : m3i_pkg::DW'(det_s4);
		dint_c = dmag_c >> m3i_pkg::SH;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_dl[0] <= dmag_c;
			side_q[0].sing <= !(dmag_c > (m3i_pkg::DW'(thr_q) << m3i_pkg::SH));
			if (dneg_c) begin
				side_q[0].dval <= (dint_c > (m3i_pkg::DW'(1) << (m3i_pkg::EW - 1)))
					? m3i_pkg::ENTRY_MIN : -$signed(dint_c[m3i_pkg::EW-1:0]);
			end else begin
				side_q[0].dval <= (dint_c >= (m3i_pkg::DW'(1) << (m3i_pkg::EW - 1)))
					? m3i_pkg::ENTRY_MAX : $signed(dint_c[m3i_pkg::EW-1:0]);
			end
			for (int k = 0; k < 9; k++) begin
				amag_s5[k] <= adj_s4[k][m3i_pkg::AW-1] ? m3i_pkg::AW'(-adj_s4[k])
					: m3i_pkg::AW'(adj_s4[k]);
				neg_s5[k] <= adj_s4[k][m3i_pkg::AW-1] ^ dneg_c;
			end
			// Shared divisor line and side data delay, aligned with the lanes.
			for (int k = 1; k <= QB; k++) begin
				dmag_dl[k] <= dmag_dl[k-1];
			end
			for (int k = 1; k <= LL; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// Nine divider lanes, one per inverse entry.
	for (genvar i = 0; i < 9; i++) begin : g_lane
		m3i_div_lane u_lane (
			.clk   (clk),
			.en    (en),
			.amag  (amag_s5[i]),
			.neg   (neg_s5[i]),
			.dmag  (dmag_dl),
			.res_q (res[i])
		);
	end

	// Output register: drop the quotients of a singular matrix.
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.b00       <= side_q[LL].sing ? '0 : res[0];
			out_q.b01       <= side_q[LL].sing ? '0 : res[1];
			out_q.b02       <= side_q[LL].sing ? '0 : res[2];
			out_q.b10       <= side_q[LL].sing ? '0 : res[3];
			out_q.b11       <= side_q[LL].sing ? '0 : res[4];
			out_q.b12       <= side_q[LL].sing ? '0 : res[5];
			out_q.b20       <= side_q[LL].sing ? '0 : res[6];
			out_q.b21       <= side_q[LL].sing ? '0 : res[7];
			out_q.b22       <= side_q[LL].sing ? '0 : res[8];
			out_q.det_value <= side_q[LL].dval;
			out_q.singular  <= side_q[LL].sing;
		end
	end

`ifndef SYNTH
	// A singular transaction carries an all-zero inverse.
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.singular |-> out_data.b00 == 0 && out_data.b01 == 0
		&& out_data.b02 == 0 && out_data.b10 == 0 && out_data.b11 == 0
		&& out_data.b12 == 0 && out_data.b20 == 0 && out_data.b21 == 0
		&& out_data.b22 == 0)
		else $error("singular result with nonzero inverse");

	// An accepted transaction enters the valid line.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_q[0])
		else $error("accepted transaction lost at pipeline entry");
`endif

endmodule
